### rtl/itm_pkg.sv
// Package for the impedance trend monitor: field widths, stream layout,
// register map codes and the pipeline stage record.
// No dependencies.
`default_nettype none

package itm_pkg;

    localparam int CH_W       = 5;
    localparam int KOHM_W     = 16;
    localparam int SLOPE_W    = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index decoded from paddr[2].
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic [KOHM_W-1:0] THRESHOLD_RESET = 16'd50;

    // One sample between the memory read and the output register.
    typedef struct packed {
        logic              ignored;
        logic [CH_W-1:0]   channel;
        logic              slope_valid;
        logic              alert;
        logic [KOHM_W-1:0] kohm;
    } stage_t;

    // One finished result.
    typedef struct packed {
        logic               log_alert_event;
        logic               alert;
        logic [SLOPE_W-1:0] trend_value;
        logic               slope_valid;
        logic [CH_W-1:0]    channel_out;
        logic               ignored;
    } result_t;

endpackage

`default_nettype wire

### rtl/impedance_trend_monitor_top.sv
// Top level of the impedance trend monitor: stream handshake, sweep
// counters, alert flags, clearing pass and output register.
// Depends on itm_pkg, itm_apb_regs, itm_history and itm_trend.
//
// Usage: each input transaction on s_tvalid/s_tready/s_tdata carries one
// impedance sample (channel, kilo-ohms). Every sample gives exactly one
// output transaction on m_tvalid/m_tready/m_tdata with the channel, the
// channel's trend, whether the trend was recomputed, and the alert flag.
// An in-range sample is written into the channel's history ring when accepted and
// the oldest slot of that ring is read in the same cycle; the trend memory
// is written when a recomputed trend leaves the read stage, with forwarding to a
// following sample of the same channel.
// A sample goes from acceptance through the read stage and output register
// to m_tvalid. One sample is accepted per cycle while the output side keeps
// up; the history memory, with one write and one read port per cycle, sets
// that rate. After reset a clearing pass over NUM_CHANNELS*HISTORY_DEPTH
// history entries (1260 by default) zeroes both memories; s_tready stays low
// during it, while APB writes are taken as usual. The threshold resets to 50.
// When the receiver stalls, the result waits in the output register, one
// more sample waits in the memory read stage, and then s_tready drops.
`default_nettype none

module impedance_trend_monitor_top
    import itm_pkg::*;
#(
    parameter int NUM_CHANNELS  = 21,
    parameter int HISTORY_DEPTH = 60
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_tdata: channel [4:0], impedance_kohm [20:5], zeros above
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: ignored [0], channel_out [5:1], slope_valid [6],
    // trend_value [22:7], alert [23], log_alert_event [24], zeros above
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int TOTAL = NUM_CHANNELS * HISTORY_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW    = $clog2(HISTORY_DEPTH + 1);
    localparam int TCW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [CH_W:0]   NUM_CH_X  = (CH_W+1)'(NUM_CHANNELS);
    localparam logic [CH_W:0]   LAST_CH_X = (CH_W+1)'(NUM_CHANNELS - 1);
    localparam logic [PW-1:0]   LAST_POS  = PW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0]   FULL_CNT  = FW'(HISTORY_DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(TOTAL - 1);

    logic [KOHM_W-1:0] threshold;

    logic [CH_W-1:0]   in_ch;
    logic [KOHM_W-1:0] in_kohm;
    logic              in_range;
    logic              accept;
    logic              item_en;
    logic              raise;

    logic              clearing_reg;
    logic              clearing_next;
    logic [AW-1:0]     clear_cnt_reg;
    logic [AW-1:0]     clear_cnt_next;
    logic              trend_clear_en;

    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [PW-1:0]     old_pos;
    logic [FW-1:0]     filled_reg;
    logic [FW-1:0]     filled_next;
    logic [NUM_CHANNELS-1:0] alert_mask_reg;
    logic [NUM_CHANNELS-1:0] alert_mask_next;

    stage_t            s1_reg;
    stage_t            s1_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_adv;

    result_t           out_reg;
    result_t           out_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [KOHM_W-1:0]  oldest;
    logic [SLOPE_W-1:0] slope;
    logic               trend_wr_en;

    itm_apb_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    assign in_ch    = s_tdata[CH_W-1:0];
    assign in_kohm  = s_tdata[CH_W +: KOHM_W];
    assign in_range = ({1'b0, in_ch} < NUM_CH_X);

    // The read stage may take a new sample whenever it empties this cycle.
    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;
    assign item_en  = accept && in_range;
    assign raise    = in_kohm > threshold;

    // The oldest slot follows the current sweep position, wrapping to zero.
    assign old_pos = (pos_reg == LAST_POS) ? '0 : (pos_reg + 1'b1);

    // Clearing pass: one history entry per cycle; the trend memory is cleared
    // while the pass count is below NUM_CHANNELS, in the same pass.
    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clearing_reg)
        begin
            if (clear_cnt_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
            end
        end
    end

    assign trend_clear_en = clearing_reg && (clear_cnt_reg < AW'(NUM_CHANNELS));

    // Sweep position, fill count and alert flags change only when an in-range sample enters.
    always_comb
    begin
        pos_next        = pos_reg;
        filled_next     = filled_reg;
        alert_mask_next = alert_mask_reg;
        if (item_en)
        begin
            alert_mask_next[in_ch[TCW-1:0]] = raise;
            if ({1'b0, in_ch} == LAST_CH_X)
            begin
                pos_next = (pos_reg == LAST_POS) ? '0 : (pos_reg + 1'b1);
                if (filled_reg < FULL_CNT)
                begin
                    filled_next = filled_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        s1_next       = s1_reg;
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_next.ignored     = !in_range;
            s1_next.channel     = in_ch;
            s1_next.slope_valid = in_range && (filled_reg >= FULL_CNT);
            s1_next.alert       = in_range && raise;
            s1_next.kohm        = in_kohm;
            s1_valid_next       = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    itm_history
    #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW),
        .PW            (PW)
    )
    u_history
    (
        .clk        (clk),
        .item_en    (item_en),
        .channel    (in_ch),
        .pos        (pos_reg),
        .old_pos    (old_pos),
        .kohm       (in_kohm),
        .clear_en   (clearing_reg),
        .clear_addr (clear_cnt_reg),
        .oldest     (oldest)
    );

    assign trend_wr_en = s1_valid_reg && s1_adv && s1_reg.slope_valid;

    itm_trend
    #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TCW          (TCW)
    )
    u_trend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (item_en),
        .rd_ch     (in_ch[TCW-1:0]),
        .wr_en     (trend_wr_en),
        .wr_ch     (s1_reg.channel[TCW-1:0]),
        .recompute (s1_reg.slope_valid),
        .kohm      (s1_reg.kohm),
        .oldest    (oldest),
        .clear_en  (trend_clear_en),
        .clear_ch  (clear_cnt_reg[TCW-1:0]),
        .slope     (slope)
    );

    // Output register; an out-of-range channel reports zero trend, slope_valid and alert.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_next.ignored         = s1_reg.ignored;
                out_next.channel_out     = s1_reg.channel;
                out_next.slope_valid     = s1_reg.slope_valid;
                out_next.trend_value     = s1_reg.ignored ? '0 : slope;
                out_next.alert           = s1_reg.alert;
                out_next.log_alert_event = s1_reg.alert;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_cnt_reg  <= '0;
            pos_reg        <= '0;
            filled_reg     <= '0;
            alert_mask_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clear_cnt_reg  <= clear_cnt_next;
            pos_reg        <= pos_next;
            filled_reg     <= filled_next;
            alert_mask_reg <= alert_mask_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    // No sample may enter while the memories are being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !clearing_reg)
        else $error("sample accepted during clearing pass");

    // An accepted sample always occupies the read stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample lost before read stage");

    // The fill count saturates at the history depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FULL_CNT)
        else $error("sweep fill count beyond history depth");

    // The sweep position only moves to the oldest slot, one step per sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> ($past(pos_reg) == LAST_POS ?
            pos_reg == '0 : pos_reg == $past(pos_reg) + 1'b1))
        else $error("sweep position skipped a slot");

    // Ignored samples never report a trend or an alert.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ignored) |->
            (!out_reg.slope_valid && !out_reg.alert && out_reg.trend_value == '0))
        else $error("ignored sample carries trend or alert");

endmodule

`default_nettype wire

### rtl/itm_apb_regs.sv
// APB register block holding the alert threshold.
// Depends on itm_pkg.
`default_nettype none

module itm_apb_regs
    import itm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [KOHM_W-1:0]     threshold
);

    logic [KOHM_W-1:0] threshold_reg;
    logic [KOHM_W-1:0] threshold_next;
    logic              wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

    always_comb
    begin
        threshold_next = threshold_reg;
        if (wr_hit)
        begin
            threshold_next = pwdata[KOHM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_THRESHOLD)
        begin
            prdata = APB_DATA_W'(threshold_reg);
        end
    end

    assign threshold = threshold_reg;

endmodule

`default_nettype wire

### rtl/itm_history.sv
// Sample history memory: one ring of samples per channel, written with the
// new sample and read at the oldest slot in the same cycle.
// Depends on itm_pkg.
`default_nettype none

module itm_history
    import itm_pkg::*;
#(
    parameter int NUM_CHANNELS  = 21,
    parameter int HISTORY_DEPTH = 60,
    parameter int AW            = 11,
    parameter int PW            = 6
)
(
    input  wire logic              clk,
    input  wire logic              item_en,
    input  wire logic [CH_W-1:0]   channel,
    input  wire logic [PW-1:0]     pos,
    input  wire logic [PW-1:0]     old_pos,
    input  wire logic [KOHM_W-1:0] kohm,
    input  wire logic              clear_en,
    input  wire logic [AW-1:0]     clear_addr,
    output logic      [KOHM_W-1:0] oldest
);

    localparam int DEPTH = NUM_CHANNELS * HISTORY_DEPTH;

    logic [KOHM_W-1:0] mem [DEPTH];
    logic [KOHM_W-1:0] rdata_reg;
    logic [AW-1:0]     base;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [KOHM_W-1:0] wr_data;

    // The oldest slot is never the slot being written, so both ports can run
    // in the same cycle without a collision.
    assign base    = AW'(channel) * AW'(HISTORY_DEPTH);
    assign rd_addr = base + AW'(old_pos);
    assign wr_en   = clear_en || item_en;
    assign wr_addr = clear_en ? clear_addr : (base + AW'(pos));
    assign wr_data = clear_en ? '0 : kohm;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (item_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign oldest = rdata_reg;

endmodule

`default_nettype wire

### rtl/itm_trend.sv
// Per-channel trend memory with read-modify-write, write-to-read forwarding
// and the trend arithmetic. Depends on itm_pkg.
`default_nettype none

module itm_trend
    import itm_pkg::*;
#(
    parameter int NUM_CHANNELS = 21,
    parameter int TCW          = 5
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [TCW-1:0]     rd_ch,
    input  wire logic               wr_en,
    input  wire logic [TCW-1:0]     wr_ch,
    input  wire logic               recompute,
    input  wire logic [KOHM_W-1:0]  kohm,
    input  wire logic [KOHM_W-1:0]  oldest,
    input  wire logic               clear_en,
    input  wire logic [TCW-1:0]     clear_ch,
    output logic      [SLOPE_W-1:0] slope
);

    logic [SLOPE_W-1:0] mem [NUM_CHANNELS];
    logic [SLOPE_W-1:0] rdata_reg;
    logic               fwd_reg;
    logic               fwd_next;
    logic [SLOPE_W-1:0] fwd_val_reg;
    logic [SLOPE_W-1:0] stored;
    logic [SLOPE_W-1:0] diff;
    logic [SLOPE_W-1:0] new_trend;
    logic               mem_we;
    logic [TCW-1:0]     mem_waddr;
    logic [SLOPE_W-1:0] mem_wdata;

    // Six times the difference as two shifted copies, wrapped to 16 bits.
    assign diff      = kohm - oldest;
    assign new_trend = (diff << 2) + (diff << 1);

    assign mem_we    = clear_en || wr_en;
    assign mem_waddr = clear_en ? clear_ch : wr_ch;
    assign mem_wdata = clear_en ? '0 : new_trend;

    // A write in the same cycle as a read of the same channel is forwarded.
    assign fwd_next = rd_en ? (wr_en && (wr_ch == rd_ch)) : fwd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg   <= mem[rd_ch];
            fwd_val_reg <= new_trend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign stored = fwd_reg ? fwd_val_reg : rdata_reg;
    assign slope  = recompute ? new_trend : stored;

endmodule

`default_nettype wire

### tb/sv/tb_impedance_trend_monitor_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for impedance_trend_monitor_top: stream driver,
// result monitor, APB threshold writes and a predictor of trend and alerts.
// Depends on itm_pkg and the impedance_trend_monitor_top RTL.
module tb_impedance_trend_monitor_top
    import itm_pkg::*;
();

    localparam int NCH            = 21;
    localparam int DEPTH          = 60;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 40;
    localparam int REPORT_LIMIT   = 10;

    // The threshold register sits at byte address 0; the block decodes paddr[2].
    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

    // One impedance sample as the sender sees it.
    typedef struct packed {
        logic [KOHM_W-1:0] kohm;
        logic [CH_W-1:0]   ch;
    } sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata: channel [4:0], impedance_kohm [20:5], zeros above
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: ignored [0], channel_out [5:1], slope_valid [6],
    // trend_value [22:7], alert [23], log_alert_event [24], zeros above
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    impedance_trend_monitor_top #(
        .NUM_CHANNELS  (NCH),
        .HISTORY_DEPTH (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the block state, advanced once per accepted sample.
    logic [KOHM_W-1:0]  hist_mem [NCH*DEPTH];
    logic [SLOPE_W-1:0] trend_mem [NCH];
    logic [NCH-1:0]     alert_bits;
    int                 sweep_pos;
    int                 sweeps_done;
    logic [KOHM_W-1:0]  threshold_shadow;

    sample_t pending_samples[$];
    result_t trend_results_due[$];
    sample_t offered_sample;

    // Stimulus control flags, written by the sequencing initial block at falling edges.
    logic calm_tail = 1'b0;
    logic long_hold_req = 1'b0;

    int src_gap;
    int sink_gap;
    int hold_left;
    bit hold_done;
    int idle_cycles;

    int samples_sent;
    int results_seen;
    int ignored_seen;
    int slopes_seen;
    int alerts_seen;
    int settings_used;
    int mismatches;

    result_t got_result;
    result_t want_result;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one sample to the shadow state and return the result the block must give.
    // Out-of-range channels leave everything untouched. The trend is only
    // recomputed once every history slot has been written, and then uses the
    // slot after the sweep position as the oldest sample.
    function automatic result_t predict_trend_result(input logic [CH_W-1:0] ch,
                                                     input logic [KOHM_W-1:0] kohm);
        result_t            r;
        int                 base;
        int                 old_pos;
        logic [SLOPE_W-1:0] diff;
        logic               raise;
        r = '0;
        r.channel_out = ch;
        if (ch >= NCH)
        begin
            r.ignored = 1'b1;
            return r;
        end
        base = int'(ch) * DEPTH;
        hist_mem[base + sweep_pos] = kohm;
        if (sweeps_done >= DEPTH)
        begin
            old_pos = (sweep_pos + 1 >= DEPTH) ? 0 : sweep_pos + 1;
            diff = kohm - hist_mem[base + old_pos];
            // Wraps modulo 2^16, read back as two's complement.
            trend_mem[ch] = diff * 16'd6;
            r.slope_valid = 1'b1;
        end
        raise = (kohm > threshold_shadow);
        alert_bits[ch] = raise;
        // The shared position only moves after the last channel of a sweep.
        if (ch == NCH - 1)
        begin
            sweep_pos = (sweep_pos + 1 >= DEPTH) ? 0 : sweep_pos + 1;
            if (sweeps_done < DEPTH)
                sweeps_done++;
        end
        r.trend_value     = trend_mem[ch];
        r.alert           = raise;
        r.log_alert_event = raise;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("Mismatch in %s at result %0d: expected 0x%0h, actual 0x%0h",
                     what, results_seen, want_v, got_v);
    endtask

    task automatic check_field(input string what, input longint unsigned want_v,
                               input longint unsigned got_v);
        if (want_v != got_v)
            note_mismatch(what, want_v, got_v);
    endtask

    // Driver: holds a transaction until the block takes it, and predicts the
    // result at the very edge at which it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                trend_results_due.push_back(
                    predict_trend_result(offered_sample.ch, offered_sample.kohm));
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (!calm_tail && $urandom_range(0, 9) == 0)
                begin
                    // Starts an idle burst; src_gap adds a random extra stretch to it.
                    src_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    offered_sample = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({offered_sample.kohm, offered_sample.ch});
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness: short random stalls, plus one long hold-off that is
    // counted here so the output register and the read stage both fill up and
    // the block has to drop s_tready while the driver keeps offering samples.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_gap  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (long_hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            sink_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: every result is matched against the oldest prediction, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            got_result = '0;
        end
        else if (m_tvalid && m_tready)
        begin
            got_result = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (trend_results_due.size() == 0)
            begin
                note_mismatch("result with no sample pending", 0, m_tdata);
            end
            else
            begin
                want_result = trend_results_due.pop_front();
                check_field("ignored", want_result.ignored, got_result.ignored);
                check_field("channel_out", want_result.channel_out, got_result.channel_out);
                check_field("slope_valid", want_result.slope_valid, got_result.slope_valid);
                check_field("trend_value", want_result.trend_value,
                            got_result.trend_value);
                check_field("alert", want_result.alert, got_result.alert);
                check_field("log_alert_event", want_result.log_alert_event,
                            got_result.log_alert_event);
                check_field("tdata padding", 0, m_tdata[M_TDATA_W-1:$bits(result_t)]);
            end
            results_seen++;
            ignored_seen += got_result.ignored;
            slopes_seen  += got_result.slope_valid;
            alerts_seen  += got_result.alert;
        end
    end

    // Watchdog: the run is declared hung after too many cycles with no transaction
    // on either stream and no APB access. The limit covers the clearing pass
    // after reset, which by itself keeps the input closed.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d quiet cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic apb_write_threshold(input logic [KOHM_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold_shadow = value;
        settings_used++;
    endtask

    task automatic apb_check_threshold();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESHOLD_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("threshold readback", APB_DATA_W'(threshold_shadow), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Every sample gives a result, so an empty prediction queue means the pipeline,
    // through the read stage and the output register, is drained.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || trend_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_sample(input int ch, input int kohm);
        sample_t s;
        s.ch   = CH_W'(ch);
        s.kohm = KOHM_W'(kohm);
        pending_samples.push_back(s);
    endtask

    // Impedance values: half full-range random, often right around the
    // threshold, sometimes at the field extremes.
    function automatic int pick_kohm();
        int unsigned mode;
        int          v;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return int'($urandom_range(0, 65535));
        if (mode < 8)
        begin
            v = int'(threshold_shadow) + int'($urandom_range(0, 4)) - 2;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return v;
        end
        return (mode == 8) ? 0 : 65535;
    endfunction

    // The history only fills after DEPTH samples of the last channel, so the
    // random mix leans on it: whole ordered sweeps, single samples weighted
    // toward the last channel, and a minority of out-of-range channels.
    task automatic queue_random_samples(input int count);
        int n;
        int c;
        int roll;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                for (c = 0; c < NCH; c++)
                    queue_sample(c, pick_kohm());
                n += NCH;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    queue_sample(NCH - 1, pick_kohm());
                else if (roll < 85)
                    queue_sample($urandom_range(0, NCH - 2), pick_kohm());
                else
                    queue_sample($urandom_range(NCH, 31), pick_kohm());
                n++;
            end
        end
    endtask

    // Sequencing: reset, directed samples at the reset threshold, then random
    // phases under several threshold settings, extremes included, with the
    // long receiver hold-off in the first random phase and a tail without idling.
    initial
    begin
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        foreach (trend_mem[i])
            trend_mem[i] = '0;
        alert_bits       = '0;
        sweep_pos        = 0;
        sweeps_done      = 0;
        threshold_shadow = THRESHOLD_RESET;
        samples_sent     = 0;
        results_seen     = 0;
        ignored_seen     = 0;
        slopes_seen      = 0;
        alerts_seen      = 0;
        settings_used    = 1;
        mismatches       = 0;
        idle_cycles      = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The reset value of the threshold must read back.
        apb_check_threshold();

        // Directed: field extremes, threshold equality versus one above,
        // out-of-range channels, channels out of order, last channel before
        // the history is full.
        @(negedge clk);
        queue_sample(0, 0);
        queue_sample(0, 50);
        queue_sample(1, 51);
        queue_sample(2, 65535);
        queue_sample(21, 100);
        queue_sample(31, 65535);
        queue_sample(NCH - 1, 0);
        queue_sample(5, 49);
        queue_sample(3, 1234);
        queue_sample(NCH - 1, 65535);
        queue_sample(19, 32768);
        queue_sample(4, 21845);
        queue_sample(10, 43690);
        queue_sample(NCH - 2, 7);
        queue_sample(0, 65534);
        queue_sample(NCH - 1, 51);
        queue_sample(26, 0);
        wait_drained();

        // Lowest threshold: any nonzero sample alerts.
        apb_write_threshold(16'd0);
        apb_check_threshold();
        @(negedge clk);
        long_hold_req = 1'b1;
        queue_random_samples(250);
        wait_drained();

        // Highest threshold: nothing can alert.
        apb_write_threshold(16'hFFFF);
        apb_check_threshold();
        @(negedge clk);
        queue_random_samples(150);
        wait_drained();

        apb_write_threshold(KOHM_W'($urandom_range(1, 65534)));
        apb_check_threshold();
        @(negedge clk);
        queue_random_samples(200);
        wait_drained();

        // Back to the reset value; the last stretch runs without idling.
        apb_write_threshold(THRESHOLD_RESET);
        @(negedge clk);
        queue_random_samples(100);
        while (pending_samples.size() > 100)
            @(negedge clk);
        calm_tail = 1'b1;
        queue_random_samples(100);
        wait_drained();

        if (trend_results_due.size() != 0)
            note_mismatch("results never delivered", 0, trend_results_due.size());

        $display("Checked %0d samples over %0d threshold settings: %0d ignored,",
                 samples_sent, settings_used, ignored_seen);
        $display("%0d with the trend recomputed, %0d with alert; %0d mismatches in total.",
                 slopes_seen, alerts_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
